[rtl/core/idal_pkg.sv]
// shared types and constants for the id allocator
`default_nettype none

package idal_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int FIRST_ID_DEF    = 2;
    localparam int COUNT_BITS_DEF  = 8;

    localparam int OP_W     = 3;
    localparam int ID_W     = 6;
    localparam int OWNER_W  = 16;
    localparam int EXIT_W   = 32;
    localparam int STATUS_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC    = 3'd0,
        OP_HOLD     = 3'd1,
        OP_RELEASE  = 3'd2,
        OP_LOOKUP   = 3'd3,
        OP_SET_EXIT = 3'd4,
        OP_WAIT     = 3'd5
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_NO_ID    = 3'd2,
        STAT_NOT_EXIT = 3'd3,
        STAT_SAT      = 3'd4
    } status_t;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic [ID_W-1:0]          entry_id;
        logic [OWNER_W-1:0]       owner_in;
        logic signed [EXIT_W-1:0] exit_in;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [ID_W-1:0]          id_out;
        logic [OWNER_W-1:0]       owner_out;
        logic signed [EXIT_W-1:0] exit_out;
        logic                     freed;
    } out_item_t;

    // scanner report to the sequencer
    typedef struct packed {
        logic            done;
        logic            found;
        logic [ID_W-1:0] id;
    } scan_res_t;

endpackage

`default_nettype wire

[rtl/core/idal_scan.sv]
// free-slot scanner: steps one id per cycle from the first usable id
`default_nettype none

module idal_scan #(
    parameter int ID_LIMIT = 64,
    parameter int FIRST_ID = 2
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [(1 << $clog2(ID_LIMIT))-1:0] in_use,
    output idal_pkg::scan_res_t                    result
);

    localparam int IDX_W = $clog2(ID_LIMIT);
    localparam int CNT_W = idal_pkg::ID_W + 1;
    localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(ID_LIMIT);
    localparam logic [CNT_W-1:0] FIRST_C = CNT_W'(FIRST_ID);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             at_end;
    logic             free_hit;

    assign at_end   = (cnt_reg >= LIMIT_C);
    assign free_hit = !in_use[cnt_reg[IDX_W-1:0]];

    always_comb begin
        result.done  = busy_reg && (at_end || free_hit);
        result.found = busy_reg && !at_end && free_hit;
        result.id    = cnt_reg[idal_pkg::ID_W-1:0];
    end

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            cnt_next  = FIRST_C;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (at_end || free_hit) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= FIRST_C;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/idal_mem.sv]
// per-entry store: count, exit flag, exit code, owner tag
`default_nettype none

module idal_mem #(
    parameter int IDX_W      = 6,
    parameter int COUNT_BITS = 8
) (
    input  wire logic                                aclk,
    input  wire logic                                rd_en,
    input  wire logic [IDX_W-1:0]                    rd_addr,
    output logic      [COUNT_BITS-1:0]               rd_count,
    output logic                                     rd_exited,
    output logic      [idal_pkg::EXIT_W-1:0]         rd_exit,
    output logic      [idal_pkg::OWNER_W-1:0]        rd_owner,
    input  wire logic                                wr_en,
    input  wire logic [IDX_W-1:0]                    wr_addr,
    input  wire logic [COUNT_BITS-1:0]               wr_count,
    input  wire logic                                wr_exited,
    input  wire logic [idal_pkg::EXIT_W-1:0]         wr_exit,
    input  wire logic [idal_pkg::OWNER_W-1:0]        wr_owner
);

    localparam int SLOTS = 1 << IDX_W;

    logic [COUNT_BITS-1:0]        count_mem [SLOTS];
    logic                         exited_mem[SLOTS];
    logic [idal_pkg::EXIT_W-1:0]  exit_mem  [SLOTS];
    logic [idal_pkg::OWNER_W-1:0] owner_mem [SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            count_mem[wr_addr]  <= wr_count;
            exited_mem[wr_addr] <= wr_exited;
            exit_mem[wr_addr]   <= wr_exit;
            owner_mem[wr_addr]  <= wr_owner;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_count  <= count_mem[rd_addr];
            rd_exited <= exited_mem[rd_addr];
            rd_exit   <= exit_mem[rd_addr];
            rd_owner  <= owner_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/id_allocator_with_refcount.sv]
// top level: id allocator with reference counts, sequencer and result register
// other ops: hold, release, lookup, set exit, wait and unused opcodes go to the exec state, which
//   registers the result, later while a result is held back; no new item is taken before that
// alloc: one id tested per scan cycle from FIRST_ID until a free id or the table end, then the
//   exec state registers the result, a full status if none; the next item is taken after that
// reset: synchronous active low, clears the in-use bits and the control; the entry store is not
//   reset and is read for every item, but its data is used only for in-use ids, which an alloc writes
`default_nettype none

module id_allocator_with_refcount #(
    parameter int TABLE_DEPTH = idal_pkg::TABLE_DEPTH_DEF,
    parameter int FIRST_ID    = idal_pkg::FIRST_ID_DEF,
    parameter int COUNT_BITS  = idal_pkg::COUNT_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire idal_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output idal_pkg::out_item_t      m_data
);

    // only ids that the 6-bit entry id can reach are kept
    localparam int ID_W     = idal_pkg::ID_W;
    localparam int ID_LIMIT = (TABLE_DEPTH < (1 << ID_W)) ? TABLE_DEPTH : (1 << ID_W);
    localparam int IDX_W    = $clog2(ID_LIMIT);
    localparam int SLOTS    = 1 << IDX_W;
    localparam logic [ID_W:0] LIMIT_C = (ID_W + 1)'(ID_LIMIT);
    localparam logic [ID_W:0] FIRST_C = (ID_W + 1)'(FIRST_ID);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // latched item
    logic [idal_pkg::OP_W-1:0]    op_reg;
    logic [ID_W-1:0]              id_reg;
    logic [idal_pkg::OWNER_W-1:0] owner_reg;
    logic [idal_pkg::EXIT_W-1:0]  exit_reg;

    // alloc outcome from the scanner
    logic            found_reg, found_next;
    logic [ID_W-1:0] alloc_id_reg, alloc_id_next;

    logic [SLOTS-1:0] in_use_reg, in_use_next;

    logic                m_valid_reg, m_valid_next;
    idal_pkg::out_item_t m_data_reg, m_data_next;

    logic accept;
    logic exec_fire;
    logic live;

    idal_pkg::scan_res_t scan_res;

    // entry store ports
    logic [COUNT_BITS-1:0]        rd_count;
    logic                         rd_exited;
    logic [idal_pkg::EXIT_W-1:0]  rd_exit;
    logic [idal_pkg::OWNER_W-1:0] rd_owner;
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    logic [COUNT_BITS-1:0]        wr_count;
    logic                         wr_exited;
    logic [idal_pkg::EXIT_W-1:0]  wr_exit;
    logic [idal_pkg::OWNER_W-1:0] wr_owner;

    // shared count unit: one adder for both raise and lower
    logic                  count_dec;
    logic [COUNT_BITS-1:0] count_sum;
    logic                  count_sat;
    logic                  count_low;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign exec_fire = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign count_dec = (op_reg == idal_pkg::OP_RELEASE);
    assign count_sum = rd_count + (count_dec ? {COUNT_BITS{1'b1}} : COUNT_BITS'(1));
    assign count_sat = (rd_count == {COUNT_BITS{1'b1}});
    assign count_low = (rd_count <= COUNT_BITS'(1));

    // range check and in-use test of the addressed id
    assign live = ({1'b0, id_reg} >= FIRST_C) && ({1'b0, id_reg} < LIMIT_C)
                  && in_use_reg[id_reg[IDX_W-1:0]];

    idal_scan #(
        .ID_LIMIT (ID_LIMIT),
        .FIRST_ID (FIRST_ID)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && (s_data.opcode == idal_pkg::OP_ALLOC)),
        .in_use  (in_use_reg),
        .result  (scan_res)
    );

    // entry read is issued on the accepting edge, data ready in the exec cycle
    idal_mem #(
        .IDX_W      (IDX_W),
        .COUNT_BITS (COUNT_BITS)
    ) u_mem (
        .aclk      (aclk),
        .rd_en     (accept),
        .rd_addr   (s_data.entry_id[IDX_W-1:0]),
        .rd_count  (rd_count),
        .rd_exited (rd_exited),
        .rd_exit   (rd_exit),
        .rd_owner  (rd_owner),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_count  (wr_count),
        .wr_exited (wr_exited),
        .wr_exit   (wr_exit),
        .wr_owner  (wr_owner)
    );

    // sequencer
    always_comb begin
        state_next    = state_reg;
        found_next    = found_reg;
        alloc_id_next = alloc_id_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.opcode == idal_pkg::OP_ALLOC) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_res.done) begin
                    found_next    = scan_res.found;
                    alloc_id_next = scan_res.id;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // read-modify-write of the entry and the result item
    always_comb begin
        in_use_next = in_use_reg;
        wr_en       = 1'b0;
        wr_addr     = id_reg[IDX_W-1:0];
        wr_count    = rd_count;
        wr_exited   = rd_exited;
        wr_exit     = rd_exit;
        wr_owner    = rd_owner;

        m_data_next.status    = idal_pkg::STAT_OK;
        m_data_next.id_out    = id_reg;
        m_data_next.owner_out = '0;
        m_data_next.exit_out  = '0;
        m_data_next.freed     = 1'b0;

        case (op_reg)
            idal_pkg::OP_ALLOC: begin
                wr_addr   = alloc_id_reg[IDX_W-1:0];
                wr_count  = COUNT_BITS'(1);
                wr_exited = 1'b0;
                wr_exit   = '0;
                wr_owner  = owner_reg;
                if (found_reg) begin
                    wr_en                                    = exec_fire;
                    in_use_next[alloc_id_reg[IDX_W-1:0]]     = 1'b1;
                    m_data_next.id_out                       = alloc_id_reg;
                end else begin
                    m_data_next.status = idal_pkg::STAT_FULL;
                    m_data_next.id_out = '0;
                end
            end
            idal_pkg::OP_HOLD, idal_pkg::OP_LOOKUP: begin
                wr_count = count_sum;
                if (!live) begin
                    m_data_next.status = idal_pkg::STAT_NO_ID;
                end else if (count_sat) begin
                    m_data_next.status = idal_pkg::STAT_SAT;
                end else begin
                    wr_en = exec_fire;
                    if (op_reg == idal_pkg::OP_LOOKUP) begin
                        m_data_next.owner_out = rd_owner;
                    end
                end
            end
            idal_pkg::OP_RELEASE: begin
                wr_count = count_low ? '0 : count_sum;
                if (!live) begin
                    m_data_next.status = idal_pkg::STAT_NO_ID;
                end else begin
                    wr_en = exec_fire;
                    if (count_low) begin
                        in_use_next[id_reg[IDX_W-1:0]] = 1'b0;
                        m_data_next.freed              = 1'b1;
                    end
                end
            end
            idal_pkg::OP_SET_EXIT: begin
                wr_exited = 1'b1;
                wr_exit   = exit_reg;
                wr_owner  = '0;
                if (!live) begin
                    m_data_next.status = idal_pkg::STAT_NO_ID;
                end else begin
                    wr_en = exec_fire;
                end
            end
            idal_pkg::OP_WAIT: begin
                if (!live) begin
                    m_data_next.status = idal_pkg::STAT_NO_ID;
                end else if (rd_exited) begin
                    m_data_next.exit_out = rd_exit;
                end else begin
                    m_data_next.status = idal_pkg::STAT_NOT_EXIT;
                end
            end
            default: begin
                // unused opcodes: plain ok echo of the id
            end
        endcase

        if (!exec_fire) begin
            in_use_next = in_use_reg;
        end
    end

    // output register
    always_comb begin
        if (exec_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            in_use_reg  <= '0;
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            in_use_reg  <= in_use_next;
            m_valid_reg <= m_valid_next;
            found_reg   <= found_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        alloc_id_reg <= alloc_id_next;
        if (accept) begin
            op_reg    <= s_data.opcode;
            id_reg    <= s_data.entry_id;
            owner_reg <= s_data.owner_in;
            exit_reg  <= s_data.exit_in;
        end
        if (exec_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    // an alloc item always goes through the scanner
    a_alloc_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_data.opcode == idal_pkg::OP_ALLOC) |=> state_reg == ST_SCAN)
        else $error("alloc item did not enter the scan");

    // the scanner only reports while an alloc is being searched
    a_scan_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !scan_res.done)
        else $error("scanner reported while idle");

    // a granted id was free when it was claimed
    a_grant_free: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire && (op_reg == idal_pkg::OP_ALLOC) && found_reg
        |-> !in_use_reg[alloc_id_reg[IDX_W-1:0]])
        else $error("alloc claimed an id already in use");

    // freeing only happens on a successful release
    a_freed_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.freed |-> m_data.status == idal_pkg::STAT_OK)
        else $error("freed flag on a failed item");

endmodule

`default_nettype wire
